### rtl/rc4_pkg.sv
package rc4_pkg;

    // Permutation table geometry.
    localparam int TABLE_SIZE = 256;
    localparam int ADDR_W     = 8;
    localparam int BYTE_W     = 8;

    // Configuration register file.
    localparam int KEY_REG_W  = 64;
    localparam int LEN_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = KEY_REG_W;

    // The two key registers together hold this many key bytes.
    localparam int KEY_BYTES_HW = 16;
    localparam int KEY_IDX_W    = 4;

    localparam int DEF_MAX_KEY_BYTES = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_KS_RD_N,
        ST_KS_RD_ACC,
        ST_KS_WR_N,
        ST_KS_WR_ACC,
        ST_RD_I,
        ST_RD_J,
        ST_WR_I,
        ST_WR_J,
        ST_HOLD
    } state_t;

endpackage

### rtl/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/rc4_stream_cipher.sv
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_ready    data_byte[7:0], last_of_message
// output    out        out_valid/out_ready  out_byte[7:0]
// config    in         cfg_write            cfg_index[1:0], cfg_data[63:0]
//
// A byte of an already keyed message passes from acceptance to the next
// acceptance through four read/write steps on the single-port-pair table RAM.
// The first byte of each message first runs the key schedule: an identity fill
// of all 256 entries, then 256 swap steps, each of four table accesses.
// Reset clears the indices and the keyed flag; the table RAM is not cleared,
// because the key schedule writes every entry before any read.
// A result waits in the output register; a stalled output holds back only the
// final step of the following byte.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::DEF_MAX_KEY_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rc4_pkg::BYTE_W-1:0]       data_byte,
    input  logic                             last_of_message,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]       out_byte
);

    import rc4_pkg::*;

    localparam int KPOS_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

    // Configuration registers.
    logic [KEY_REG_W-1:0] key_low_reg;
    logic [KEY_REG_W-1:0] key_high_reg;
    logic [LEN_W-1:0]     key_len_reg;

    // Control state.
    state_t state_reg, state_next;
    logic   keyed_reg, keyed_next;
    logic   out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;

    // Working registers.
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic [KPOS_W-1:0] kpos_reg, kpos_next;
    logic [BYTE_W-1:0] si_reg, si_next;
    logic [BYTE_W-1:0] sj_reg, sj_next;
    logic [ADDR_W-1:0] t_reg, t_next;
    logic [BYTE_W-1:0] res_reg, res_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              last_reg, last_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;

    // Table RAM port signals.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    logic              in_take;
    logic              out_free;
    logic              out_load;
    logic [BYTE_W-1:0] key_bytes [KEY_BYTES_HW];
    logic [BYTE_W-1:0] key_byte;
    logic [LEN_W-1:0]  len_eff;
    logic              kpos_wrap;
    logic [ADDR_W-1:0] acc_sum;
    logic [BYTE_W-1:0] keystream;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Key bytes 0..7 come from the low register, 8..15 from the high one.
    for (genvar k = 0; k < KEY_BYTES_HW / 2; k++)
    begin : g_key
        assign key_bytes[k]                    = key_low_reg[k*BYTE_W +: BYTE_W];
        assign key_bytes[k + KEY_BYTES_HW / 2] = key_high_reg[k*BYTE_W +: BYTE_W];
    end

    assign key_byte = key_bytes[KEY_IDX_W'(kpos_reg)];

    // A zero length acts as one, and lengths saturate at the supported maximum.
    always_comb
    begin
        if (key_len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (key_len_reg > LEN_W'(MAX_KEY_BYTES))
        begin
            len_eff = LEN_W'(MAX_KEY_BYTES);
        end
        else
        begin
            len_eff = key_len_reg;
        end
    end

    assign kpos_wrap = (LEN_W'(kpos_reg) + LEN_W'(1)) >= len_eff;
    assign acc_sum   = acc_reg + ram_rdata + key_byte;

    // The keystream index was read before the swap landed in the table, so a
    // hit on either swapped entry takes the swapped value instead. When both
    // indices are equal the two candidates carry the same byte.
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            keystream = si_reg;
        end
        else if (t_reg == i_reg)
        begin
            keystream = sj_reg;
        end
        else
        begin
            keystream = ram_rdata;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = keyed_reg ? ST_RD_I : ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = ST_KS_RD_N;
                end
            end
            ST_KS_RD_N:   state_next = ST_KS_RD_ACC;
            ST_KS_RD_ACC: state_next = ST_KS_WR_N;
            ST_KS_WR_N:   state_next = ST_KS_WR_ACC;
            ST_KS_WR_ACC: state_next = (cnt_reg == '1) ? ST_RD_I : ST_KS_RD_N;
            ST_RD_I:      state_next = ST_RD_J;
            ST_RD_J:      state_next = ST_WR_I;
            ST_WR_I:      state_next = ST_WR_J;
            ST_WR_J:      state_next = out_free ? ST_IDLE : ST_HOLD;
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Memory accesses and datapath updates.
    always_comb
    begin
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = cnt_reg;
        ram_re        = 1'b0;
        ram_raddr     = cnt_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        kpos_next     = kpos_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        si_next       = si_reg;
        sj_next       = sj_reg;
        t_next        = t_reg;
        res_next      = res_reg;
        data_next     = data_reg;
        last_next     = last_reg;
        keyed_next    = keyed_reg;
        out_load      = 1'b0;
        out_byte_next = out_byte_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    data_next = data_byte;
                    last_next = last_of_message;
                    if (!keyed_reg)
                    begin
                        cnt_next  = '0;
                        acc_next  = '0;
                        kpos_next = '0;
                    end
                end
            end
            ST_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + ADDR_W'(1);
            end
            ST_KS_RD_N:
            begin
                ram_re = 1'b1;
            end
            ST_KS_RD_ACC:
            begin
                si_next   = ram_rdata;
                acc_next  = acc_sum;
                ram_re    = 1'b1;
                ram_raddr = acc_sum;
            end
            ST_KS_WR_N:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_KS_WR_ACC:
            begin
                ram_we    = 1'b1;
                ram_waddr = acc_reg;
                ram_wdata = si_reg;
                cnt_next  = cnt_reg + ADDR_W'(1);
                kpos_next = kpos_wrap ? '0 : kpos_reg + KPOS_W'(1);
                if (cnt_reg == '1)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    keyed_next = 1'b1;
                end
            end
            ST_RD_I:
            begin
                i_next    = i_reg + ADDR_W'(1);
                ram_re    = 1'b1;
                ram_raddr = i_reg + ADDR_W'(1);
            end
            ST_RD_J:
            begin
                si_next   = ram_rdata;
                j_next    = j_reg + ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = j_reg + ram_rdata;
            end
            ST_WR_I:
            begin
                sj_next   = ram_rdata;
                t_next    = si_reg + ram_rdata;
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = ram_rdata;
                ram_re    = 1'b1;
                ram_raddr = si_reg + ram_rdata;
            end
            ST_WR_J:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                res_next  = data_reg ^ keystream;
                if (last_reg)
                begin
                    keyed_next = 1'b0;
                end
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = data_reg ^ keystream;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_byte_next = res_reg;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Configuration writes; indexes past the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                CFG_KEY_HIGH: key_high_reg <= cfg_data;
                CFG_KEY_LEN:  key_len_reg  <= cfg_data[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        acc_reg      <= acc_next;
        kpos_reg     <= kpos_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        res_reg      <= res_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
    end

    // The keyed flag drops only when the last byte of a message finishes.
    a_keyed_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(keyed_reg) |-> $past(state_reg == ST_WR_J && last_reg))
        else $error("keyed flag cleared outside the end of a message");

    // No result is produced while the key schedule owns the table.
    a_no_out_in_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL || state_reg == ST_KS_RD_N || state_reg == ST_KS_RD_ACC
         || state_reg == ST_KS_WR_N || state_reg == ST_KS_WR_ACC) |-> !out_load)
        else $error("output loaded during key schedule");

    // An accepted request is worked on before another one is taken.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !in_ready)
        else $error("second request taken while one is in progress");

    // A pending result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(out_byte_reg))
        else $error("pending result overwritten");

endmodule
